FILE: src/rtst_pkg.sv
// rtst_pkg: shared types and constants for the repeating timer slot table
// used by rtst_cell and repeating_timer_slot_table_unit; no dependencies

package rtst_pkg;

  // default number of timer slots
  localparam int unsigned TIMER_SLOTS_DEF = 16;

  // most firings reported for one tick
  localparam int unsigned MAX_FIRES = 16;

  // a repeat count at or above this never counts down
  localparam logic [16:0] FOREVER_COUNT = 17'd99999;

  localparam int unsigned NOW_W  = 32;
  localparam int unsigned WAIT_W = 16;
  localparam int unsigned REPS_W = 17;

  typedef enum logic [1:0] {
    CmdTick   = 2'd0,
    CmdAdd    = 2'd1,
    CmdDelete = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StPick,
    StFlush
  } state_e;

  // per-cell update strobes from the controller
  typedef struct packed {
    logic add;
    logic clear;
    logic fire;
  } cell_ctl_t;

endpackage

FILE: src/rtst_cell.sv
// rtst_cell: one timer slot plus one stage of the deadline compare chain
// depends on rtst_pkg

module rtst_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned IdxW    = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rtst_pkg::cell_ctl_t         ctl_i,
  input  logic [rtst_pkg::NOW_W-1:0]  now_i,
  input  logic [rtst_pkg::WAIT_W-1:0] wait_i,
  input  logic [rtst_pkg::REPS_W-1:0] reps_i,
  input  logic                        tok_valid_i,
  input  logic [rtst_pkg::NOW_W-1:0]  tok_over_i,
  input  logic [IdxW-1:0]             tok_idx_i,
  input  logic [rtst_pkg::REPS_W-1:0] tok_reps_i,
  output logic                        tok_valid_o,
  output logic [rtst_pkg::NOW_W-1:0]  tok_over_o,
  output logic [IdxW-1:0]             tok_idx_o,
  output logic [rtst_pkg::REPS_W-1:0] tok_reps_o,
  output logic                        free_o
);

  logic [rtst_pkg::WAIT_W-1:0] interval_q, interval_d;
  logic [rtst_pkg::NOW_W-1:0]  start_q, start_d;
  logic [rtst_pkg::REPS_W-1:0] reps_q, reps_d;
  logic [rtst_pkg::NOW_W-1:0]  elapsed_q;

  logic                        tok_valid_q;
  logic [rtst_pkg::NOW_W-1:0]  tok_over_q;
  logic [IdxW-1:0]             tok_idx_q;
  logic [rtst_pkg::REPS_W-1:0] tok_reps_q;

  logic [rtst_pkg::NOW_W:0]    diff;
  logic                        due;
  logic                        take;

  // borrow of elapsed - interval tells whether the slot is due
  assign diff = {1'b0, elapsed_q} - {{(rtst_pkg::NOW_W + 1 - rtst_pkg::WAIT_W){1'b0}}, interval_q};
  assign due  = (interval_q != '0) && !diff[rtst_pkg::NOW_W];
  // strictly later wins, so lower slots keep ties
  assign take = due && (!tok_valid_i || (diff[rtst_pkg::NOW_W-1:0] > tok_over_i));

  always_comb begin
    interval_d = interval_q;
    start_d    = start_q;
    reps_d     = reps_q;
    if (ctl_i.add) begin
      interval_d = wait_i;
      start_d    = now_i;
      reps_d     = reps_i;
    end else if (ctl_i.clear) begin
      interval_d = '0;
    end else if (ctl_i.fire) begin
      if (reps_q <= rtst_pkg::REPS_W'(1)) begin
        interval_d = '0;
      end else begin
        if (reps_q < rtst_pkg::FOREVER_COUNT) begin
          reps_d = reps_q - rtst_pkg::REPS_W'(1);
        end
        start_d = now_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= '0;
      tok_valid_q <= 1'b0;
    end else begin
      interval_q  <= interval_d;
      tok_valid_q <= take || tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    reps_q    <= reps_d;
    elapsed_q <= now_i - start_q;
    if (take) begin
      tok_over_q <= diff[rtst_pkg::NOW_W-1:0];
      tok_idx_q  <= IdxW'(CellIdx);
      tok_reps_q <= reps_q;
    end else begin
      tok_over_q <= tok_over_i;
      tok_idx_q  <= tok_idx_i;
      tok_reps_q <= tok_reps_i;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_over_o  = tok_over_q;
  assign tok_idx_o   = tok_idx_q;
  assign tok_reps_o  = tok_reps_q;
  assign free_o      = (interval_q == '0);

endmodule

FILE: src/repeating_timer_slot_table_unit.sv
// repeating_timer_slot_table_unit: top level, controller over a chain of slot cells
// depends on rtst_pkg and rtst_cell

// A table of TIMER_SLOTS repeating timers. Add, delete and unused commands
// finish without leaving idle: busy stays low and the single result
// (last = 1) shows on the cycle after the transfer. A tick raises busy and
// bumps the seconds counter; the deadline compare then ripples through the
// row of slot cells, one cell a cycle, to find the most overdue slot. A tick
// holds busy while it searches again after each firing and reports one
// firing per search, the last marked by last = 1; a tick with nothing due
// gives no result. Results are valid for one cycle on valid_o and cannot be
// held off by the receiver.

module repeating_timer_slot_table_unit #(
  parameter int unsigned TIMER_SLOTS = rtst_pkg::TIMER_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd_i,
  input  logic [15:0]                 wait_seconds_i,
  input  logic [16:0]                 repeat_count_i,
  input  logic [3:0]                  slot_i,
  output logic                        valid_o,
  output logic                        fired_o,
  output logic                        accepted_o,
  output logic [3:0]                  slot_index_o,
  output logic [16:0]                 repeats_left_o,
  output logic                        last_o
);

  localparam int unsigned IdxW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned FcntW = $clog2(rtst_pkg::MAX_FIRES + 1);

  rtst_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [FcntW-1:0] fcnt_q, fcnt_d;
  logic [rtst_pkg::NOW_W-1:0] now_q, now_d;

  logic                        pend_v_q, pend_v_d;
  logic [IdxW-1:0]             pend_idx_q, pend_idx_d;
  logic [rtst_pkg::REPS_W-1:0] pend_reps_q, pend_reps_d;

  logic        res_v_q, res_v_d;
  logic        res_fired_q, res_fired_d;
  logic        res_acc_q, res_acc_d;
  logic [3:0]  res_idx_q, res_idx_d;
  logic [16:0] res_reps_q, res_reps_d;
  logic        res_last_q, res_last_d;

  // token chain, position i feeds cell i
  logic                        tok_valid [TIMER_SLOTS+1];
  logic [rtst_pkg::NOW_W-1:0]  tok_over  [TIMER_SLOTS+1];
  logic [IdxW-1:0]             tok_idx   [TIMER_SLOTS+1];
  logic [rtst_pkg::REPS_W-1:0] tok_reps  [TIMER_SLOTS+1];

  logic [TIMER_SLOTS-1:0] free;
  rtst_pkg::cell_ctl_t    ctl [TIMER_SLOTS];

  logic            any_free;
  logic [IdxW-1:0] free_idx;
  logic            add_en, del_en, fire_en;
  logic [IdxW-1:0] fire_idx;

  assign tok_valid[0] = 1'b0;
  assign tok_over[0]  = '0;
  assign tok_idx[0]   = '0;
  assign tok_reps[0]  = '0;

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    rtst_cell #(
      .CellIdx (g),
      .IdxW    (IdxW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl[g]),
      .now_i       (now_q),
      .wait_i      (wait_seconds_i),
      .reps_i      (repeat_count_i),
      .tok_valid_i (tok_valid[g]),
      .tok_over_i  (tok_over[g]),
      .tok_idx_i   (tok_idx[g]),
      .tok_reps_i  (tok_reps[g]),
      .tok_valid_o (tok_valid[g+1]),
      .tok_over_o  (tok_over[g+1]),
      .tok_idx_o   (tok_idx[g+1]),
      .tok_reps_o  (tok_reps[g+1]),
      .free_o      (free[g])
    );
  end

  // lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (free[i]) begin
        any_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      ctl[i].add   = add_en && (free_idx == IdxW'(i));
      ctl[i].clear = del_en && ({28'd0, slot_i} == 32'(i));
      ctl[i].fire  = fire_en && (fire_idx == IdxW'(i));
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fcnt_d      = fcnt_q;
    now_d       = now_q;
    pend_v_d    = pend_v_q;
    pend_idx_d  = pend_idx_q;
    pend_reps_d = pend_reps_q;
    res_v_d     = 1'b0;
    res_fired_d = 1'b0;
    res_acc_d   = 1'b0;
    res_idx_d   = '0;
    res_reps_d  = '0;
    res_last_d  = 1'b1;
    add_en      = 1'b0;
    del_en      = 1'b0;
    fire_en     = 1'b0;
    fire_idx    = tok_idx[TIMER_SLOTS];
    busy        = 1'b1;

    unique case (state_q)
      rtst_pkg::StIdle: begin
        busy = 1'b0;
        if (start) begin
          unique case (cmd_i)
            rtst_pkg::CmdTick: begin
              now_d    = now_q + rtst_pkg::NOW_W'(1);
              cnt_d    = '0;
              fcnt_d   = '0;
              pend_v_d = 1'b0;
              state_d  = rtst_pkg::StScan;
            end
            rtst_pkg::CmdAdd: begin
              res_v_d = 1'b1;
              if ((wait_seconds_i != '0) && any_free) begin
                add_en    = 1'b1;
                res_acc_d = 1'b1;
                res_idx_d = 4'(free_idx);
              end
            end
            rtst_pkg::CmdDelete: begin
              res_v_d   = 1'b1;
              res_idx_d = slot_i;
              if ({28'd0, slot_i} < 32'(TIMER_SLOTS)) begin
                del_en    = 1'b1;
                res_acc_d = 1'b1;
              end
            end
            default: begin
              res_v_d = 1'b1;
            end
          endcase
        end
      end

      rtst_pkg::StScan: begin
        // wait until the compare has rippled through every cell
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(TIMER_SLOTS)) begin
          state_d = rtst_pkg::StPick;
        end
      end

      rtst_pkg::StPick: begin
        if (tok_valid[TIMER_SLOTS]) begin
          // the earlier firing is now known not to be the last
          if (pend_v_q) begin
            res_v_d     = 1'b1;
            res_fired_d = 1'b1;
            res_idx_d   = 4'(pend_idx_q);
            res_reps_d  = pend_reps_q;
            res_last_d  = 1'b0;
          end
          pend_v_d    = 1'b1;
          pend_idx_d  = tok_idx[TIMER_SLOTS];
          pend_reps_d = tok_reps[TIMER_SLOTS];
          fire_en     = 1'b1;
          fcnt_d      = fcnt_q + FcntW'(1);
          cnt_d       = '0;
          if (fcnt_q == FcntW'(rtst_pkg::MAX_FIRES - 1)) begin
            state_d = rtst_pkg::StFlush;
          end else begin
            state_d = rtst_pkg::StScan;
          end
        end else begin
          if (pend_v_q) begin
            res_v_d     = 1'b1;
            res_fired_d = 1'b1;
            res_idx_d   = 4'(pend_idx_q);
            res_reps_d  = pend_reps_q;
          end
          pend_v_d = 1'b0;
          state_d  = rtst_pkg::StIdle;
        end
      end

      rtst_pkg::StFlush: begin
        res_v_d     = 1'b1;
        res_fired_d = 1'b1;
        res_idx_d   = 4'(pend_idx_q);
        res_reps_d  = pend_reps_q;
        pend_v_d    = 1'b0;
        state_d     = rtst_pkg::StIdle;
      end

      default: begin
        state_d = rtst_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rtst_pkg::StIdle;
      cnt_q    <= '0;
      fcnt_q   <= '0;
      now_q    <= '0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      fcnt_q   <= fcnt_d;
      now_q    <= now_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    pend_reps_q <= pend_reps_d;
    res_fired_q <= res_fired_d;
    res_acc_q   <= res_acc_d;
    res_idx_q   <= res_idx_d;
    res_reps_q  <= res_reps_d;
    res_last_q  <= res_last_d;
  end

  assign valid_o        = res_v_q;
  assign fired_o        = res_fired_q;
  assign accepted_o     = res_acc_q;
  assign slot_index_o   = res_idx_q;
  assign repeats_left_o = res_reps_q;
  assign last_o         = res_last_q;

endmodule

FILE: bench/tb.sv
// tb: self-checking bench for repeating_timer_slot_table_unit
// keeps its own copy of the slot table, predicts each report and checks it
// depends on rtst_pkg and the block's sources

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_SLOTS      = rtst_pkg::TIMER_SLOTS_DEF;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned MAX_GAP        = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // a tick may still be searching after its last firing
  localparam int unsigned DRAIN_CYCLES   = 5 * (NUM_SLOTS + 2);

  typedef struct packed {
    logic                        fired;
    logic                        accepted;
    logic [3:0]                  slot_index;
    logic [rtst_pkg::REPS_W-1:0] repeats_left;
    logic                        last;
  } timer_report_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [1:0]                  cmd_i;
  logic [rtst_pkg::WAIT_W-1:0] wait_seconds_i;
  logic [rtst_pkg::REPS_W-1:0] repeat_count_i;
  logic [3:0]                  slot_i;
  logic                        valid_o;
  logic                        fired_o;
  logic                        accepted_o;
  logic [3:0]                  slot_index_o;
  logic [rtst_pkg::REPS_W-1:0] repeats_left_o;
  logic                        last_o;

  repeating_timer_slot_table_unit #(
    .TIMER_SLOTS(NUM_SLOTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .wait_seconds_i (wait_seconds_i),
    .repeat_count_i (repeat_count_i),
    .slot_i         (slot_i),
    .valid_o        (valid_o),
    .fired_o        (fired_o),
    .accepted_o     (accepted_o),
    .slot_index_o   (slot_index_o),
    .repeats_left_o (repeats_left_o),
    .last_o         (last_o)
  );

  // shadow copy of the timer table
  logic [rtst_pkg::NOW_W-1:0]  now_sec;
  logic [rtst_pkg::WAIT_W-1:0] tmr_interval [NUM_SLOTS];
  logic [rtst_pkg::NOW_W-1:0]  tmr_start    [NUM_SLOTS];
  logic [rtst_pkg::REPS_W-1:0] tmr_reps     [NUM_SLOTS];

  timer_report_t expected_reports[$];
  int unsigned   fail_count;
  int unsigned   sender_idle_pct;
  int unsigned   quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic timer_report_t make_report(logic fired, logic acc, logic [3:0] idx,
                                                logic [rtst_pkg::REPS_W-1:0] reps,
                                                logic last);
    timer_report_t r;
    r.fired        = fired;
    r.accepted     = acc;
    r.slot_index   = idx;
    r.repeats_left = reps;
    r.last         = last;
    return r;
  endfunction

  function automatic void clear_slot(int s);
    tmr_interval[s] = '0;
    tmr_start[s]    = '0;
    tmr_reps[s]     = '0;
  endfunction

  // one tick: bump the clock, then fire due slots most overdue first
  function automatic void predict_tick();
    timer_report_t               fires [rtst_pkg::MAX_FIRES];
    int                          n_fired;
    int                          pick;
    logic [rtst_pkg::NOW_W-1:0]  elapsed;
    logic [rtst_pkg::NOW_W-1:0]  over;
    logic [rtst_pkg::NOW_W-1:0]  best_over;
    logic [rtst_pkg::REPS_W-1:0] c;
    logic                        searching;
    n_fired   = 0;
    searching = 1'b1;
    now_sec   = now_sec + 1;
    while (searching && n_fired < rtst_pkg::MAX_FIRES) begin
      pick      = -1;
      best_over = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (tmr_interval[i] != '0) begin
          elapsed = now_sec - tmr_start[i];
          if (elapsed >= {16'd0, tmr_interval[i]}) begin
            over = elapsed - {16'd0, tmr_interval[i]};
            if (pick < 0 || over > best_over) begin
              pick      = i;
              best_over = over;
            end
          end
        end
      end
      if (pick < 0) begin
        searching = 1'b0;
      end else begin
        c = tmr_reps[pick];
        fires[n_fired] = make_report(1'b1, 1'b0, pick[3:0], c, 1'b0);
        n_fired++;
        if (c <= 1) begin
          clear_slot(pick);
        end else begin
          if (c < rtst_pkg::FOREVER_COUNT) tmr_reps[pick] = c - 17'd1;
          tmr_start[pick] = now_sec;
        end
      end
    end
    for (int k = 0; k < n_fired; k++) begin
      if (k == n_fired - 1) fires[k].last = 1'b1;
      expected_reports.push_back(fires[k]);
    end
  endfunction

  function automatic void predict_timer_table(logic [1:0] cmd,
                                              logic [rtst_pkg::WAIT_W-1:0] w,
                                              logic [rtst_pkg::REPS_W-1:0] r,
                                              logic [3:0] s);
    int free_slot;
    free_slot = -1;
    unique case (cmd)
      rtst_pkg::CmdTick: begin
        predict_tick();
      end
      rtst_pkg::CmdAdd: begin
        if (w != '0) begin
          for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (tmr_interval[i] == '0) free_slot = i;
          end
        end
        if (free_slot < 0) begin
          expected_reports.push_back(make_report(1'b0, 1'b0, 4'd0, '0, 1'b1));
        end else begin
          tmr_interval[free_slot] = w;
          tmr_start[free_slot]    = now_sec;
          tmr_reps[free_slot]     = r;
          expected_reports.push_back(make_report(1'b0, 1'b1, free_slot[3:0], '0, 1'b1));
        end
      end
      rtst_pkg::CmdDelete: begin
        if (int'(s) >= NUM_SLOTS) begin
          expected_reports.push_back(make_report(1'b0, 1'b0, s, '0, 1'b1));
        end else begin
          clear_slot(int'(s));
          expected_reports.push_back(make_report(1'b0, 1'b1, s, '0, 1'b1));
        end
      end
      default: begin
        expected_reports.push_back(make_report(1'b0, 1'b0, 4'd0, '0, 1'b1));
      end
    endcase
  endfunction

  function automatic void compare_report(timer_report_t exp_r);
    if (fired_o !== exp_r.fired) begin
      $error("fired: expected %0d, got %0d", exp_r.fired, fired_o);
      fail_count++;
    end
    if (accepted_o !== exp_r.accepted) begin
      $error("accepted: expected %0d, got %0d", exp_r.accepted, accepted_o);
      fail_count++;
    end
    if (slot_index_o !== exp_r.slot_index) begin
      $error("slot_index: expected %0d, got %0d", exp_r.slot_index, slot_index_o);
      fail_count++;
    end
    if (repeats_left_o !== exp_r.repeats_left) begin
      $error("repeats_left: expected %0d, got %0d", exp_r.repeats_left, repeats_left_o);
      fail_count++;
    end
    if (last_o !== exp_r.last) begin
      $error("last: expected %0d, got %0d", exp_r.last, last_o);
      fail_count++;
    end
  endfunction

  // check reports first, then predict the transfer taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o === 1'b1) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: slot_index %0d fired %0d", slot_index_o, fired_o);
          fail_count++;
        end else begin
          compare_report(expected_reports.pop_front());
        end
      end
      if (start && !busy) predict_timer_table(cmd_i, wait_seconds_i, repeat_count_i, slot_i);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o === 1'b1) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // start is left high after the transfer so the next command can follow at once
  task automatic send_cmd(logic [1:0] cmd, logic [rtst_pkg::WAIT_W-1:0] w,
                          logic [rtst_pkg::REPS_W-1:0] r, logic [3:0] s);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < MAX_GAP) begin
      start <= 1'b0;
      gap++;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    cmd_i          <= cmd;
    wait_seconds_i <= w;
    repeat_count_i <= r;
    slot_i         <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic test_idle_table();
    send_cmd(rtst_pkg::CmdTick, 16'hffff, 17'h1ffff, 4'hf);
    send_cmd(rtst_pkg::CmdDelete, 16'd0, 17'd0, 4'd15);
    send_cmd(CMD_UNUSED, 16'h5a5a, 17'h0a5a5, 4'd9);
  endtask

  task automatic test_zero_wait();
    send_cmd(rtst_pkg::CmdAdd, 16'd0, rtst_pkg::FOREVER_COUNT, 4'd0);
  endtask

  // fifteen one-second timers tie on the same tick, the last slot holds the extremes
  task automatic test_full_table();
    for (int i = 0; i < NUM_SLOTS - 1; i++) begin
      send_cmd(rtst_pkg::CmdAdd, 16'd1, (i == 3) ? 17'd0 : 17'd1, 4'(i));
    end
    send_cmd(rtst_pkg::CmdAdd, 16'hffff, 17'h1ffff, 4'd0);
    send_cmd(rtst_pkg::CmdAdd, 16'd7, 17'd5, 4'd0);
    send_cmd(rtst_pkg::CmdTick, 16'd0, 17'd0, 4'd0);
    send_cmd(rtst_pkg::CmdDelete, 16'd0, 17'd0, 4'(NUM_SLOTS - 1));
  endtask

  task automatic test_repeat_countdown();
    send_cmd(rtst_pkg::CmdAdd, 16'd2, 17'd2, 4'd0);
    repeat (4) send_cmd(rtst_pkg::CmdTick, 16'd0, 17'd0, 4'd0);
  endtask

  task automatic test_random_traffic(int n_items, int unsigned idle_pct);
    int unsigned                 sel;
    int unsigned                 k;
    logic [1:0]                  cmd;
    logic [rtst_pkg::WAIT_W-1:0] w;
    logic [rtst_pkg::REPS_W-1:0] r;
    logic [3:0]                  s;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) cmd = rtst_pkg::CmdTick;
      else if (sel < 75) cmd = rtst_pkg::CmdAdd;
      else if (sel < 95) cmd = rtst_pkg::CmdDelete;
      else cmd = CMD_UNUSED;
      // mostly short waits so timers actually expire
      k = $urandom_range(0, 99);
      if (k < 80) w = 16'($urandom_range(1, 6));
      else if (k < 95) w = 16'($urandom_range(0, 65535));
      else w = '0;
      k = $urandom_range(0, 99);
      if (k < 35) r = 17'($urandom_range(0, 4));
      else if (k < 55) r = rtst_pkg::FOREVER_COUNT;
      else r = 17'($urandom_range(0, 99999));
      s = 4'($urandom_range(0, 15));
      send_cmd(cmd, w, r, s);
    end
  endtask

  initial begin
    fail_count      = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 0;
    now_sec         = '0;
    for (int i = 0; i < NUM_SLOTS; i++) clear_slot(i);
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    cmd_i          <= rtst_pkg::CmdTick;
    wait_seconds_i <= '0;
    repeat_count_i <= '0;
    slot_i         <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_table();
    test_zero_wait();
    test_full_table();
    test_repeat_countdown();
    test_random_traffic(38, 0);
    test_random_traffic(38, 68);
    test_random_traffic(38, 0);
    test_random_traffic(38, 14);

    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
